// ===== rtl/eci_pkg.sv =====
// Shared constants, types and the cosine easing table for the ease curve interpolator.
`timescale 1ns / 1ps

package eci_pkg;

    localparam int FRACTION_BITS  = 16;
    localparam int COS_TABLE_BITS = 8;

    localparam int FX_ONE  = 1 << FRACTION_BITS;
    localparam int FX_HALF = FX_ONE >> 1;
    localparam int ROM_N   = 1 << COS_TABLE_BITS;

    // Progress arrives as Q1.16 and is moved to the internal fraction width.
    localparam int UP_SHIFT  = (FRACTION_BITS > 16) ? FRACTION_BITS - 16 : 0;
    localparam int DN_SHIFT  = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
    localparam int ROUND_ADD = (1 << DN_SHIFT) >> 1;

    // Curve select codes; the two unused codes fall back to linear.
    localparam logic [2:0] CURVE_LINEAR   = 3'd0;
    localparam logic [2:0] CURVE_COSINE   = 3'd1;
    localparam logic [2:0] CURVE_CUBIC    = 3'd2;
    localparam logic [2:0] CURVE_EASE_IN  = 3'd3;
    localparam logic [2:0] CURVE_EASE_OUT = 3'd4;
    localparam logic [2:0] CURVE_IN_OUT   = 3'd5;

    typedef longint unsigned u64_t;
    typedef logic [FRACTION_BITS:0] factor_t;
    typedef logic [FRACTION_BITS-1:0] frac_t;
    typedef logic [COS_TABLE_BITS:0] rom_idx_t;
    typedef factor_t cos_rom_t [0:ROM_N];

    localparam u64_t PI_Q30   = 64'd3373259426;
    localparam u64_t ROM_N_U  = u64_t'(ROM_N);
    localparam u64_t FX_ONE_U = u64_t'(FX_ONE);

    // Shift-and-subtract quotient, used only while the table is built.
    function automatic u64_t series_div(u64_t num, u64_t den);
        u64_t quo;
        u64_t rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & u64_t'(1));
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | (u64_t'(1) << b);
            end
        end
        return quo;
    endfunction

    // Half of one minus cosine of the entry angle in Q16, from a ten-term series in Q30.
    function automatic u64_t cos_rom_low(u64_t i);
        u64_t    theta;
        u64_t    th2;
        u64_t    term;
        longint  s;
        theta = (PI_Q30 * i) >> COS_TABLE_BITS;
        th2   = (theta * theta) >> 30;
        term  = th2 >> 1;
        s     = 0;
        for (int k = 1; k <= 10; k++) begin
            if (k > 1) begin
                term = series_div((term * th2) >> 30, u64_t'((2 * k - 1) * (2 * k)));
            end
            if ((k & 1) == 1) begin
                s = s + longint'(term);
            end else begin
                s = s - longint'(term);
            end
        end
        if (s < 0) begin
            s = 0;
        end
        return ((u64_t'(s) << FRACTION_BITS) + (u64_t'(1) << 30)) >> 31;
    endfunction

    function automatic cos_rom_t build_cos_rom();
        cos_rom_t r;
        u64_t     v;
        for (int i = 0; i <= ROM_N; i++) begin
            if (i <= ROM_N / 2) begin
                r[i] = factor_t'(cos_rom_low(u64_t'(i)));
            end else begin
                v    = cos_rom_low(u64_t'(ROM_N - i));
                r[i] = (v > FX_ONE_U) ? '0 : factor_t'(FX_ONE_U - v);
            end
        end
        return r;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

// ===== rtl/eci_cos_lookup.sv =====
// Cosine table lookup: the two neighboring entries and the interpolation fraction.
`timescale 1ns / 1ps

module eci_cos_lookup (
    input  eci_pkg::factor_t t,
    output eci_pkg::factor_t e0,
    output eci_pkg::factor_t e1,
    output eci_pkg::frac_t   fr
);

    localparam int SW = eci_pkg::FRACTION_BITS + 1 + eci_pkg::COS_TABLE_BITS;

    logic [SW-1:0]     scaled;
    eci_pkg::rom_idx_t idx;
    eci_pkg::rom_idx_t idx_up;
    eci_pkg::factor_t  lo_entry;
    eci_pkg::factor_t  hi_entry;

    assign scaled = SW'(t) << eci_pkg::COS_TABLE_BITS;
    assign idx    = scaled[SW-1:eci_pkg::FRACTION_BITS];
    assign fr     = scaled[eci_pkg::FRACTION_BITS-1:0];
    assign idx_up = idx + 1'b1;

    always_comb begin
        if (idx >= eci_pkg::rom_idx_t'(eci_pkg::ROM_N)) begin
            // At full progress the top entry stands alone.
            lo_entry = eci_pkg::COS_ROM[eci_pkg::ROM_N];
            hi_entry = lo_entry;
        end else begin
            lo_entry = eci_pkg::COS_ROM[idx];
            hi_entry = eci_pkg::COS_ROM[idx_up];
            if (hi_entry < lo_entry) begin
                hi_entry = lo_entry;
            end
        end
    end

    assign e0 = lo_entry;
    assign e1 = hi_entry;

endmodule

// ===== rtl/ease_curve_interpolator.sv =====
// Ease curve interpolator: five-stage pipeline from progress and curve to position.
// A beat moves through the stage registers one to four and the output register to m_valid.
// Throughput: one beat per cycle while m_ready does not stall the chain; each stage
// holds one beat, with one multiplier in each of stages two, three and four.
// Reset: aresetn (synchronous, active low) clears every stage valid bit.
// Data registers are not reset; a stall holds the stages that cannot move on.
`timescale 1ns / 1ps

module ease_curve_interpolator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_start_pos,
    input  logic signed [15:0] s_end_pos,
    input  logic signed [17:0] s_progress,
    input  logic        [2:0]  s_operation,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_position
);

    localparam int FB  = eci_pkg::FRACTION_BITS;
    localparam int WW  = FB + 2;
    localparam int MW  = FB + 3;
    localparam int FW  = FB + 5;
    localparam int PW  = FB + 19;
    localparam int SCW = 18 + eci_pkg::UP_SHIFT;

    localparam logic [WW-1:0] ONE_W  = WW'(eci_pkg::FX_ONE);
    localparam logic [WW-1:0] HALF_W = WW'(eci_pkg::FX_HALF);

    // Handshake of the stage chain.
    logic v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    logic r1, r2, r3, r4, r5;

    assign r5      = !m_valid_reg || m_ready;
    assign r4      = !v4_reg || r5;
    assign r3      = !v3_reg || r4;
    assign r2      = !v2_reg || r3;
    assign r1      = !v1_reg || r2;
    assign s_ready = r1;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (r1) v1_reg      <= s_valid;
            if (r2) v2_reg      <= v1_reg;
            if (r3) v3_reg      <= v2_reg;
            if (r4) v4_reg      <= v3_reg;
            if (r5) m_valid_reg <= v4_reg;
        end
    end

    // Stage 1: clamp progress, take span bounds, read the cosine table.
    logic [16:0]      p_clamp;
    logic [SCW-1:0]   p_scaled;
    logic [SCW-1:0]   p_shift;
    eci_pkg::factor_t t1;
    eci_pkg::factor_t e0_1, e1_1;
    eci_pkg::frac_t   fr_1;

    always_comb begin
        if (s_progress[17]) begin
            p_clamp = '0;
        end else if (s_progress > 18'sd65536) begin
            p_clamp = 17'd65536;
        end else begin
            p_clamp = s_progress[16:0];
        end
        p_scaled = (SCW'(p_clamp) << eci_pkg::UP_SHIFT) + SCW'(eci_pkg::ROUND_ADD);
        p_shift  = p_scaled >> eci_pkg::DN_SHIFT;
        t1 = (p_shift > SCW'(eci_pkg::FX_ONE)) ? eci_pkg::factor_t'(eci_pkg::FX_ONE)
                                               : p_shift[FB:0];
    end

    eci_cos_lookup u_cos (
        .t  (t1),
        .e0 (e0_1),
        .e1 (e1_1),
        .fr (fr_1)
    );

    logic signed [15:0] a1_reg, lo1_reg, hi1_reg;
    logic signed [16:0] d1_reg;
    logic [2:0]         op1_reg;
    eci_pkg::factor_t   t1_reg, e01_reg, e11_reg;
    eci_pkg::frac_t     fr1_reg;

    always_ff @(posedge aclk) begin
        if (r1) begin
            a1_reg  <= s_start_pos;
            d1_reg  <= 17'(s_end_pos) - 17'(s_start_pos);
            lo1_reg <= (s_start_pos < s_end_pos) ? s_start_pos : s_end_pos;
            hi1_reg <= (s_start_pos < s_end_pos) ? s_end_pos : s_start_pos;
            op1_reg <= s_operation;
            t1_reg  <= t1;
            e01_reg <= e0_1;
            e11_reg <= e1_1;
            fr1_reg <= fr_1;
        end
    end

    // Stage 2: first product, shared by every curve that needs one.
    logic [WW-1:0]   tw, gw, x2, y2, z2;
    logic            low2;
    logic [2*WW-1:0] prod2;
    logic [WW-1:0]   m1_2;

    always_comb begin
        tw   = WW'(t1_reg);
        gw   = (ONE_W << 1) - (tw << 1);
        low2 = tw < HALF_W;
        z2   = '0;
        case (op1_reg)
            eci_pkg::CURVE_COSINE: begin
                x2 = WW'(e11_reg - e01_reg);
                y2 = WW'(fr1_reg);
            end
            eci_pkg::CURVE_CUBIC: begin
                x2 = tw;
                y2 = tw;
                z2 = (ONE_W << 1) + ONE_W - (tw << 1);
            end
            eci_pkg::CURVE_EASE_OUT: begin
                x2 = tw;
                y2 = (ONE_W << 1) - tw;
            end
            eci_pkg::CURVE_IN_OUT: begin
                x2 = low2 ? tw : gw;
                y2 = x2;
                z2 = x2;
            end
            default: begin
                x2 = tw;
                y2 = tw;
            end
        endcase
        prod2 = (2*WW)'(x2) * (2*WW)'(y2);
        m1_2  = WW'((prod2 + (2*WW)'(eci_pkg::FX_HALF)) >> FB);
    end

    logic signed [15:0] a2_reg, lo2_reg, hi2_reg;
    logic signed [16:0] d2_reg;
    logic [2:0]         op2_reg;
    logic               low2_reg;
    eci_pkg::factor_t   t2_reg, e02_reg;
    logic [WW-1:0]      m12_reg, z2_reg;

    always_ff @(posedge aclk) begin
        if (r2) begin
            a2_reg   <= a1_reg;
            d2_reg   <= d1_reg;
            lo2_reg  <= lo1_reg;
            hi2_reg  <= hi1_reg;
            op2_reg  <= op1_reg;
            low2_reg <= low2;
            t2_reg   <= t1_reg;
            e02_reg  <= e01_reg;
            m12_reg  <= m1_2;
            z2_reg   <= z2;
        end
    end

    // Stage 3: second product and the curve factor.
    logic [2*WW-1:0]  prod3;
    logic [MW-1:0]    m2_3;
    logic [FW-1:0]    f_wide, half_g3;
    eci_pkg::factor_t f3;

    always_comb begin
        prod3   = (2*WW)'(m12_reg) * (2*WW)'(z2_reg);
        m2_3    = MW'((prod3 + (2*WW)'(eci_pkg::FX_HALF)) >> FB);
        half_g3 = (FW'(m2_3) + FW'(1)) >> 1;
        case (op2_reg)
            eci_pkg::CURVE_COSINE:   f_wide = FW'(e02_reg) + FW'(m12_reg);
            eci_pkg::CURVE_CUBIC:    f_wide = FW'(m2_3);
            eci_pkg::CURVE_EASE_IN:  f_wide = FW'(m12_reg);
            eci_pkg::CURVE_EASE_OUT: f_wide = FW'(m12_reg);
            eci_pkg::CURVE_IN_OUT: begin
                if (low2_reg) begin
                    f_wide = FW'(m2_3) << 2;
                end else if (half_g3 > FW'(eci_pkg::FX_ONE)) begin
                    f_wide = '0;
                end else begin
                    f_wide = FW'(eci_pkg::FX_ONE) - half_g3;
                end
            end
            default:                 f_wide = FW'(t2_reg);
        endcase
        f3 = (f_wide > FW'(eci_pkg::FX_ONE)) ? eci_pkg::factor_t'(eci_pkg::FX_ONE)
                                             : f_wide[FB:0];
    end

    logic signed [15:0] a3_reg, lo3_reg, hi3_reg;
    logic signed [16:0] d3_reg;
    eci_pkg::factor_t   f3_reg;

    always_ff @(posedge aclk) begin
        if (r3) begin
            a3_reg  <= a2_reg;
            d3_reg  <= d2_reg;
            lo3_reg <= lo2_reg;
            hi3_reg <= hi2_reg;
            f3_reg  <= f3;
        end
    end

    // Stage 4: scale the span by the factor.
    logic signed [PW-1:0] prod4;

    assign prod4 = PW'(d3_reg) * PW'($signed({1'b0, f3_reg}));

    logic signed [15:0]   a4_reg, lo4_reg, hi4_reg;
    logic signed [PW-1:0] prod4_reg;

    always_ff @(posedge aclk) begin
        if (r4) begin
            a4_reg    <= a3_reg;
            lo4_reg   <= lo3_reg;
            hi4_reg   <= hi3_reg;
            prod4_reg <= prod4;
        end
    end

    // Stage 5: round half up, offset by the start and keep within the span.
    logic signed [PW-1:0] rnd5, step5;
    logic signed [17:0]   pos5, pos_clamp;

    always_comb begin
        rnd5  = prod4_reg + PW'(eci_pkg::FX_HALF);
        step5 = rnd5 >>> FB;
        pos5  = 18'(a4_reg) + $signed(step5[17:0]);
        if (pos5 < 18'(lo4_reg)) begin
            pos_clamp = 18'(lo4_reg);
        end else if (pos5 > 18'(hi4_reg)) begin
            pos_clamp = 18'(hi4_reg);
        end else begin
            pos_clamp = pos5;
        end
    end

    logic signed [15:0] m_position_reg;

    always_ff @(posedge aclk) begin
        if (r5) begin
            m_position_reg <= pos_clamp[15:0];
        end
    end

    assign m_position = m_position_reg;

endmodule

// ===== rtl/eci_checker.sv =====
// Port-level checks for the ease curve interpolator, bound to the top level.
`timescale 1ns / 1ps

module eci_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_position
);

    // A result beat that is held back keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_position))
        else $error("result beat changed while stalled");

    // With the output stage empty, the whole pipeline can take a beat.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with an empty output stage");

    // With m_ready held high, an accepted beat comes out of the pipeline.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && m_ready) ##1 m_ready ##1 m_ready ##1 m_ready ##1 m_ready
        |=> m_valid)
        else $error("result beat missing after pipeline latency");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind ease_curve_interpolator eci_checker u_eci_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_position (m_position)
);
